[sv/uidal_pkg.sv]
// uidal_pkg: shared types and constants for the card identifier allow list table.
// Used by uidal_front, uidal_queue, uidal_back and uid_allow_list_table.
package uidal_pkg;

    localparam int TABLE_ROWS_DEF = 256;
    localparam int KEY_BITS_DEF   = 32;
    localparam int CARD_KEY_BITS  = 32;
    localparam int FUNC_BITS      = 2;
    localparam int STATUS_BITS    = 2;
    localparam int ROW_INDEX_BITS = 8;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [FUNC_BITS-1:0] {
        FN_LOOKUP = 2'd0,
        FN_ADD    = 2'd1,
        FN_REMOVE = 2'd2
    } func_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_SCAN,
        BK_FINISH
    } back_state_t;

    // Decoded request as it travels from front to back
    typedef struct packed {
        logic    do_scan;
        logic    do_write;
        logic    hit_on_match;
        status_t miss_status;
    } cmd_t;

endpackage

[sv/uidal_front.sv]
// uidal_front: accepts request beats and decodes them into scan commands.
// Depends on uidal_pkg; feeds uidal_queue.
module uidal_front #(
    parameter int KEY_BITS = uidal_pkg::KEY_BITS_DEF
) (
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [uidal_pkg::FUNC_BITS-1:0]      s_func,
    input  logic [uidal_pkg::CARD_KEY_BITS-1:0]  s_card_key,
    input  logic                                 q_full,
    input  logic                                 clearing,
    output logic                                 q_push,
    output uidal_pkg::cmd_t                      q_cmd,
    output logic [KEY_BITS-1:0]                  q_target,
    output logic [KEY_BITS-1:0]                  q_wdata
);

    localparam logic [KEY_BITS-1:0] EMPTY_KEY = '1;

    logic [KEY_BITS+uidal_pkg::CARD_KEY_BITS-1:0] key_ext;
    logic [KEY_BITS-1:0]                          key;

    assign key_ext = {{KEY_BITS{1'b0}}, s_card_key};
    assign key     = key_ext[KEY_BITS-1:0];

    assign s_ready = !q_full && !clearing;
    assign q_push  = s_valid && s_ready;

    always_comb begin
        q_cmd.do_scan      = 1'b1;
        q_cmd.do_write     = 1'b0;
        q_cmd.hit_on_match = 1'b0;
        q_cmd.miss_status  = uidal_pkg::ST_NOT_FOUND;
        q_target           = key;
        q_wdata            = EMPTY_KEY;
        unique case (uidal_pkg::func_t'(s_func))
            uidal_pkg::FN_LOOKUP: begin
                q_cmd.hit_on_match = 1'b1;
            end
            uidal_pkg::FN_ADD: begin
                q_cmd.do_write    = 1'b1;
                q_cmd.miss_status = uidal_pkg::ST_FULL;
                q_target          = EMPTY_KEY;
                q_wdata           = key;
            end
            uidal_pkg::FN_REMOVE: begin
                q_cmd.do_write     = 1'b1;
                q_cmd.hit_on_match = 1'b1;
            end
            default: begin
                // unused code: no scan, plain done result
                q_cmd.do_scan     = 1'b0;
                q_cmd.miss_status = uidal_pkg::ST_DONE;
            end
        endcase
    end

endmodule

[sv/uidal_queue.sv]
// uidal_queue: short command queue between front and back.
// Depends on uidal_pkg for its depth.
module uidal_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] head_data
);

    localparam int DEPTH    = uidal_pkg::QUEUE_DEPTH;
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

    logic [WIDTH-1:0]    slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_BITS'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_BITS'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_BITS'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[sv/uidal_back.sv]
// uidal_back: table memory, clearing pass, row scan engine and result register.
// Depends on uidal_pkg; takes commands from uidal_queue.
module uidal_back #(
    parameter int TABLE_ROWS = uidal_pkg::TABLE_ROWS_DEF,
    parameter int KEY_BITS   = uidal_pkg::KEY_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 q_valid,
    input  uidal_pkg::cmd_t                      q_cmd,
    input  logic [KEY_BITS-1:0]                  q_target,
    input  logic [KEY_BITS-1:0]                  q_wdata,
    output logic                                 q_pop,
    output logic                                 clearing,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_hit,
    output logic [uidal_pkg::STATUS_BITS-1:0]    m_status,
    output logic [uidal_pkg::ROW_INDEX_BITS-1:0] m_row_index
);

    localparam int ROW_BITS = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
    localparam int IDX_BITS = uidal_pkg::ROW_INDEX_BITS;
    localparam logic [ROW_BITS-1:0] LAST_ROW  = ROW_BITS'(TABLE_ROWS - 1);
    localparam logic [KEY_BITS-1:0] EMPTY_KEY = '1;

    logic [KEY_BITS-1:0] key_mem [TABLE_ROWS];
    logic [KEY_BITS-1:0] rd_data_reg;

    uidal_pkg::back_state_t state_reg, state_next;
    logic [ROW_BITS-1:0]    issue_reg, issue_next;
    logic                   issue_done_reg, issue_done_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    logic [ROW_BITS-1:0]    cmp_row_reg, cmp_row_next;
    logic                   found_reg, found_next;
    logic [ROW_BITS-1:0]    found_row_reg, found_row_next;
    uidal_pkg::cmd_t        cmd_reg;
    logic [KEY_BITS-1:0]    target_reg;
    logic [KEY_BITS-1:0]    wdata_reg;
    logic                   load_cmd;

    logic                   m_valid_reg, m_valid_next;
    logic                   m_hit_reg, m_hit_next;
    uidal_pkg::status_t     m_status_reg, m_status_next;
    logic [IDX_BITS-1:0]    m_row_reg, m_row_next;
    logic                   res_load;

    logic                   mem_we;
    logic [ROW_BITS-1:0]    mem_waddr;
    logic [KEY_BITS-1:0]    mem_wdata;
    logic                   match;
    logic [ROW_BITS+IDX_BITS-1:0] row_ext;

    assign match    = cmp_valid_reg && (rd_data_reg == target_reg);
    assign row_ext  = {{IDX_BITS{1'b0}}, found_row_reg};
    assign clearing = (state_reg == uidal_pkg::BK_CLEAR);

    always_comb begin
        state_next      = state_reg;
        issue_next      = issue_reg;
        issue_done_next = issue_done_reg;
        cmp_valid_next  = 1'b0;
        cmp_row_next    = issue_reg;
        found_next      = found_reg;
        found_row_next  = found_row_reg;
        q_pop           = 1'b0;
        load_cmd        = 1'b0;
        res_load        = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = issue_reg;
        mem_wdata       = EMPTY_KEY;
        m_hit_next      = m_hit_reg;
        m_status_next   = m_status_reg;
        m_row_next      = m_row_reg;
        unique case (state_reg)
            uidal_pkg::BK_CLEAR: begin
                mem_we = 1'b1;
                if (issue_reg == LAST_ROW) begin
                    issue_next = '0;
                    state_next = uidal_pkg::BK_IDLE;
                end else begin
                    issue_next = issue_reg + ROW_BITS'(1);
                end
            end
            uidal_pkg::BK_IDLE: begin
                if (q_valid) begin
                    q_pop           = 1'b1;
                    load_cmd        = 1'b1;
                    issue_next      = '0;
                    issue_done_next = 1'b0;
                    found_next      = 1'b0;
                    state_next      = q_cmd.do_scan ? uidal_pkg::BK_SCAN
                                                    : uidal_pkg::BK_FINISH;
                end
            end
            uidal_pkg::BK_SCAN: begin
                if (!issue_done_reg) begin
                    cmp_valid_next = 1'b1;
                    if (issue_reg == LAST_ROW) begin
                        issue_done_next = 1'b1;
                    end else begin
                        issue_next = issue_reg + ROW_BITS'(1);
                    end
                end
                if (match) begin
                    found_next     = 1'b1;
                    found_row_next = cmp_row_reg;
                    cmp_valid_next = 1'b0;
                    state_next     = uidal_pkg::BK_FINISH;
                end else if (cmp_valid_reg && (cmp_row_reg == LAST_ROW)) begin
                    cmp_valid_next = 1'b0;
                    state_next     = uidal_pkg::BK_FINISH;
                end
            end
            uidal_pkg::BK_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    res_load      = 1'b1;
                    mem_we        = found_reg && cmd_reg.do_write;
                    mem_waddr     = found_row_reg;
                    mem_wdata     = wdata_reg;
                    m_hit_next    = found_reg && cmd_reg.hit_on_match;
                    m_status_next = found_reg ? uidal_pkg::ST_DONE : cmd_reg.miss_status;
                    m_row_next    = found_reg ? row_ext[IDX_BITS-1:0] : '0;
                    state_next    = uidal_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = uidal_pkg::BK_IDLE;
            end
        endcase
        if (res_load) begin
            m_valid_next = 1'b1;
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= uidal_pkg::BK_CLEAR;
            issue_reg      <= '0;
            issue_done_reg <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            issue_reg      <= issue_next;
            issue_done_reg <= issue_done_next;
            cmp_valid_reg  <= cmp_valid_next;
            found_reg      <= found_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmp_row_reg   <= cmp_row_next;
        found_row_reg <= found_row_next;
        m_hit_reg     <= m_hit_next;
        m_status_reg  <= m_status_next;
        m_row_reg     <= m_row_next;
        if (load_cmd) begin
            cmd_reg    <= q_cmd;
            target_reg <= q_target;
            wdata_reg  <= q_wdata;
        end
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= key_mem[issue_reg];
    end

    assign m_valid     = m_valid_reg;
    assign m_hit       = m_hit_reg;
    assign m_status    = m_status_reg;
    assign m_row_index = m_row_reg;

    a_match_ends_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == uidal_pkg::BK_SCAN) && match |=> (state_reg == uidal_pkg::BK_FINISH))
        else $error("scan did not stop on a matching row");

    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == uidal_pkg::BK_SCAN) |-> !mem_we)
        else $error("table written during a scan");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == uidal_pkg::BK_FINISH))
        else $error("result beat raised outside finish");

    a_full_has_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_status_reg == uidal_pkg::ST_FULL) |-> !m_hit_reg)
        else $error("table full reported with a hit");

endmodule

[sv/uid_allow_list_table.sv]
// uid_allow_list_table: top level of the card identifier allow list table.
// Instantiates uidal_front, uidal_queue and uidal_back; depends on uidal_pkg.
//
// Each request beat (lookup, add or remove of a card key) gives exactly one result beat.
// Requests are taken into a two-entry command queue and carried out one at a time by a
// scan engine that reads the table memory one row per cycle through its single read port.
// A request passes through the pop from the queue, the row reads, the registered read and
// the result load; a lookup or remove that matches early, or an add that finds an empty
// row early, ends at that row. An unused operation code skips the scan and goes from the
// pop straight to the result load. After reset a clearing pass fills every row with all
// ones; s_ready stays low until it is done. Row indexes above 255 wrap modulo 256.
module uid_allow_list_table #(
    parameter int TABLE_ROWS = uidal_pkg::TABLE_ROWS_DEF,
    parameter int KEY_BITS   = uidal_pkg::KEY_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [uidal_pkg::FUNC_BITS-1:0]      s_func,
    input  logic [uidal_pkg::CARD_KEY_BITS-1:0]  s_card_key,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_hit,
    output logic [uidal_pkg::STATUS_BITS-1:0]    m_status,
    output logic [uidal_pkg::ROW_INDEX_BITS-1:0] m_row_index
);

    localparam int CMD_BITS = $bits(uidal_pkg::cmd_t);
    localparam int Q_WIDTH  = CMD_BITS + 2 * KEY_BITS;

    logic                q_push;
    logic                q_full;
    logic                q_pop;
    logic                q_not_empty;
    logic                clearing;
    uidal_pkg::cmd_t     push_cmd;
    logic [KEY_BITS-1:0] push_target;
    logic [KEY_BITS-1:0] push_wdata;
    logic [Q_WIDTH-1:0]  push_data;
    logic [Q_WIDTH-1:0]  head_data;
    uidal_pkg::cmd_t     head_cmd;
    logic [KEY_BITS-1:0] head_target;
    logic [KEY_BITS-1:0] head_wdata;

    assign push_data = {push_cmd, push_target, push_wdata};
    assign head_cmd  = uidal_pkg::cmd_t'(head_data[Q_WIDTH-1 -: CMD_BITS]);
    assign head_target = head_data[2*KEY_BITS-1 -: KEY_BITS];
    assign head_wdata  = head_data[KEY_BITS-1:0];

    uidal_front #(
        .KEY_BITS (KEY_BITS)
    ) u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_card_key (s_card_key),
        .q_full     (q_full),
        .clearing   (clearing),
        .q_push     (q_push),
        .q_cmd      (push_cmd),
        .q_target   (push_target),
        .q_wdata    (push_wdata)
    );

    uidal_queue #(
        .WIDTH (Q_WIDTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_data (head_data)
    );

    uidal_back #(
        .TABLE_ROWS (TABLE_ROWS),
        .KEY_BITS   (KEY_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_not_empty),
        .q_cmd       (head_cmd),
        .q_target    (head_target),
        .q_wdata     (head_wdata),
        .q_pop       (q_pop),
        .clearing    (clearing),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hit       (m_hit),
        .m_status    (m_status),
        .m_row_index (m_row_index)
    );

endmodule
